/* hdl/mf16c_pkg.sv */
// Package with payload types, codes and constants for the minifloat converter.
`timescale 1ns / 1ps
`default_nettype none
package mf16c_pkg;

  typedef enum logic [0:0] {
    FUNC_MF_TO_F32 = 1'b0,
    FUNC_F32_TO_MF = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_NAN       = 2'd3
  } status_t;

  typedef struct packed {
    func_t       func;
    logic [31:0] operand_bits;
  } in_item_t;

  typedef struct packed {
    logic [31:0] converted_bits;
    status_t     status;
  } out_item_t;

  localparam logic [15:0] MF_POS_MAX  = 16'h7FFF;
  localparam logic [15:0] MF_NEG_MAX  = 16'h8000;
  localparam logic [15:0] MF_NEG_ZERO = 16'hFFFF;
  localparam logic [7:0]  F32_BIAS    = 8'd127;
  localparam logic [7:0]  MF_BIAS     = 8'd16;

endpackage
`default_nettype wire

/* hdl/minifloat16_binary32_converter_core.sv */
// Minifloat16 to binary32 converter core, both directions, one transaction per cycle.
//
//   channel | ports                           | handshake
//   --------+---------------------------------+---------------------------------
//   input   | start, busy, in_item            | accepted when start && !busy
//   result  | out_valid, out_item             | one-cycle strobe, never stalled
//
// An operand is captured in the input register, converted by shallow logic and
// lands in the result register, and the result strobe follows start through both registers.
// A new transaction can be accepted every cycle; busy is held low.
// Synchronous active-low reset clears the valid flags only.
// The receiver cannot stall, so no result is ever held back.
`timescale 1ns / 1ps
`default_nettype none
module minifloat16_binary32_converter_core
  import mf16c_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  output out_item_t      out_item
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t res_nxt;

  // Decode-side signals.
  logic [15:0] mf_x;
  logic [15:0] mf_mag;
  // Encode-side signals.
  logic        f_neg;
  logic [7:0]  f_exp;
  logic [22:0] f_frac;
  logic [11:0] f_rnd;
  logic [8:0]  f_exp_adj;
  logic [9:0]  f_frac_out;
  logic [15:0] mf_enc;

  assign busy = 1'b0;

  // Input and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= start;
      out_valid_r <= in_valid_r;
    end
    if (start) begin
      in_item_r <= in_item;
    end
    out_item_r <= res_nxt;
  end

  // Conversion logic for both directions.
  always_comb begin
    mf_x       = in_item_r.operand_bits[15:0];
    mf_mag     = mf_x[15] ? ~mf_x : mf_x;
    f_neg      = in_item_r.operand_bits[31];
    f_exp      = in_item_r.operand_bits[30:23];
    f_frac     = in_item_r.operand_bits[22:0];
    // Round the 24-bit significand to 11 bits, halves away from zero.
    f_rnd      = 12'(({1'b0, 1'b1, f_frac} + 25'h1000) >> 13);
    f_exp_adj  = {1'b0, f_exp} + 9'(f_rnd[11]);
    f_frac_out = f_rnd[11] ? 10'd0 : f_rnd[9:0];
    mf_enc     = {1'b0, 5'(f_exp_adj - 9'(F32_BIAS - MF_BIAS)), f_frac_out};
    res_nxt    = '{converted_bits: 32'd0, status: ST_OK};
    unique case (in_item_r.func)
      FUNC_MF_TO_F32: begin
        if (mf_x != 16'h0000 && mf_x != MF_NEG_ZERO) begin
          res_nxt.converted_bits = {mf_x[15],
                                    8'({3'd0, mf_mag[14:10]}) + (F32_BIAS - MF_BIAS),
                                    mf_mag[9:0], 13'd0};
        end
      end
      FUNC_F32_TO_MF: begin
        if (f_exp == 8'hFF) begin
          if (f_frac != 23'd0) begin
            res_nxt = '{converted_bits: {16'd0, MF_POS_MAX}, status: ST_NAN};
          end else begin
            res_nxt = '{converted_bits: {16'd0, f_neg ? MF_NEG_MAX : MF_POS_MAX},
                        status: ST_OVERFLOW};
          end
        end else if (f_exp == 8'd0) begin
          if (f_frac != 23'd0) begin
            res_nxt = '{converted_bits: {16'd0, f_neg ? MF_NEG_ZERO : 16'h0000},
                        status: ST_UNDERFLOW};
          end
        end else if (f_exp_adj > 9'd142) begin
          // Rounded exponent above 15.
          res_nxt = '{converted_bits: {16'd0, f_neg ? MF_NEG_MAX : MF_POS_MAX},
                      status: ST_OVERFLOW};
        end else if (f_exp_adj < 9'd111) begin
          // Rounded exponent below -16.
          res_nxt = '{converted_bits: {16'd0, f_neg ? MF_NEG_ZERO : 16'h0000},
                      status: ST_UNDERFLOW};
        end else begin
          res_nxt.converted_bits = {16'd0, f_neg ? ~mf_enc : mf_enc};
        end
      end
      default: res_nxt = '{converted_bits: 32'd0, status: ST_OK};
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the minifloat16 / binary32 converter core.
`timescale 1ns / 1ps
module testbench;
  import mf16c_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  minifloat16_binary32_converter_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  localparam int STALL_LIMIT = 2000;

  in_item_t  pending_ops[$];
  out_item_t expected_conv[$];
  int        fail_count = 0;
  int        idle_cycles = 0;
  int        gap_left = 0;
  bit        stim_done = 0;

  // Decode a minifloat into the exact binary32 pattern.
  function automatic out_item_t decode_mf(logic [15:0] mf);
    out_item_t   r;
    logic        neg;
    logic [15:0] mag;
    r.status = ST_OK;
    r.converted_bits = '0;
    if (mf != 16'h0000 && mf != MF_NEG_ZERO) begin
      neg = mf[15];
      mag = neg ? ~mf : mf;
      r.converted_bits = {neg, 8'(mag[14:10] + 8'd111), mag[9:0], 13'b0};
    end
    return r;
  endfunction

  // Encode a binary32 pattern into a minifloat, rounding halves away from zero.
  function automatic out_item_t encode_f32(logic [31:0] f);
    out_item_t   r;
    logic        neg;
    logic [7:0]  ef;
    logic [22:0] frac;
    logic [24:0] rnd;
    logic [10:0] sig;
    int          e;
    logic [15:0] mf;
    neg = f[31];
    ef = f[30:23];
    frac = f[22:0];
    r.converted_bits = '0;
    r.status = ST_OK;
    if (ef == 8'hFF) begin
      if (frac != 0) begin
        r.converted_bits = {16'h0, MF_POS_MAX};
        r.status = ST_NAN;
      end else begin
        r.converted_bits = {16'h0, neg ? MF_NEG_MAX : MF_POS_MAX};
        r.status = ST_OVERFLOW;
      end
    end else if (ef == 8'h00) begin
      if (frac != 0) begin
        r.converted_bits = {16'h0, neg ? MF_NEG_ZERO : 16'h0000};
        r.status = ST_UNDERFLOW;
      end
    end else begin
      e = int'(ef) - 127;
      rnd = {2'b01, frac} + 25'h1000;
      sig = rnd[23:13];
      if (rnd[24]) begin
        sig = 11'h400;
        e = e + 1;
      end
      if (e > 15) begin
        r.converted_bits = {16'h0, neg ? MF_NEG_MAX : MF_POS_MAX};
        r.status = ST_OVERFLOW;
      end else if (e < -16) begin
        r.converted_bits = {16'h0, neg ? MF_NEG_ZERO : 16'h0000};
        r.status = ST_UNDERFLOW;
      end else begin
        mf = {1'b0, 5'(e + 16), sig[9:0]};
        if (neg) mf = ~mf;
        r.converted_bits = {16'h0, mf};
      end
    end
    return r;
  endfunction

  function automatic out_item_t convert(in_item_t it);
    if (it.func == FUNC_MF_TO_F32) return decode_mf(it.operand_bits[15:0]);
    return encode_f32(it.operand_bits);
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic add_op(func_t fn, logic [31:0] bits);
    in_item_t it;
    it.func = fn;
    it.operand_bits = bits;
    pending_ops.push_back(it);
  endtask

  // Random binary32 that mostly lands in or near the minifloat range.
  function automatic logic [31:0] rand_f32();
    logic [31:0] v;
    int p;
    v = $urandom;
    p = $urandom_range(0, 99);
    if (p < 65) v[30:23] = 8'($urandom_range(107, 146));
    else if (p < 72) v[30:23] = 8'hFF;
    else if (p < 79) v[30:23] = 8'h00;
    if (p >= 65 && p < 79 && $urandom_range(0, 2) == 0) v[22:0] = '0;
    if ($urandom_range(0, 5) == 0) v[12:0] = $urandom_range(0, 1) ? 13'h1000 : 13'h0FFF;
    if ($urandom_range(0, 7) == 0) v[22:13] = 10'h3FF;
    return v;
  endfunction

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Stimulus: directed corners first, then random operands.
  initial begin
    rst_n = 0;
    add_op(FUNC_MF_TO_F32, 32'h0000_0000);
    add_op(FUNC_MF_TO_F32, 32'hFFFF_FFFF);
    add_op(FUNC_MF_TO_F32, 32'hABCD_7FFF);
    add_op(FUNC_MF_TO_F32, 32'h0000_8000);
    add_op(FUNC_MF_TO_F32, 32'h5555_0001);
    add_op(FUNC_MF_TO_F32, 32'h0000_FFFE);
    add_op(FUNC_MF_TO_F32, 32'h0000_4000);
    add_op(FUNC_F32_TO_MF, 32'h0000_0000);
    add_op(FUNC_F32_TO_MF, 32'h8000_0000);
    add_op(FUNC_F32_TO_MF, 32'h7F80_0000);
    add_op(FUNC_F32_TO_MF, 32'hFF80_0000);
    add_op(FUNC_F32_TO_MF, 32'h7FC0_0000);
    add_op(FUNC_F32_TO_MF, 32'hFFFF_FFFF);
    add_op(FUNC_F32_TO_MF, 32'h0000_0001);
    add_op(FUNC_F32_TO_MF, 32'h807F_FFFF);
    add_op(FUNC_F32_TO_MF, 32'h477F_F000);
    add_op(FUNC_F32_TO_MF, 32'h477F_E000);
    add_op(FUNC_F32_TO_MF, 32'hC77F_F000);
    add_op(FUNC_F32_TO_MF, 32'h3780_0000);
    add_op(FUNC_F32_TO_MF, 32'hB780_0000);
    add_op(FUNC_F32_TO_MF, 32'h377F_F000);
    add_op(FUNC_F32_TO_MF, 32'h377F_E000);
    add_op(FUNC_F32_TO_MF, 32'h3F80_1000);
    add_op(FUNC_F32_TO_MF, 32'hBF80_0FFF);
    for (int i = 0; i < 950; i++) begin
      if ($urandom_range(0, 1)) add_op(FUNC_MF_TO_F32, $urandom);
      else add_op(FUNC_F32_TO_MF, rand_f32());
    end
    repeat (7) @(posedge clk);
    rst_n <= 1;
  end

  // Driver: presents queued transactions with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start   <= 1'b0;
      in_item <= '0;
      gap_left <= pick_gap();
    end else begin
      if (start && !busy) begin
        expected_conv.push_back(convert(in_item));
      end
      if (start && busy) begin
        // Hold the current transaction until it is taken.
      end else if (gap_left > 0 || pending_ops.size() == 0) begin
        start <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
        if (pending_ops.size() == 0 && !(start && !busy)) stim_done <= 1'b1;
      end else begin
        start   <= 1'b1;
        in_item <= pending_ops.pop_front();
        gap_left <= pick_gap();
      end
    end
  end

  // Monitor: checks each result against the oldest prediction.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_conv.size() == 0) begin
        $error("unexpected result: converted_bits %h status %0d",
               out_item.converted_bits, out_item.status);
        fail_count++;
      end else begin
        want = expected_conv.pop_front();
        if (out_item.converted_bits !== want.converted_bits) begin
          $error("converted_bits: expected %h actual %h",
                 want.converted_bits, out_item.converted_bits);
          fail_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_item.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog and end of run.
  initial begin
    int drain;
    drain = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
      if (stim_done && expected_conv.size() == 0) begin
        drain++;
        if (drain >= 10) break;
      end
    end
    if (fail_count == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
